[src/fixed_point_decimal_formatter_assert.svh]
// Assertion macros shared by the formatter RTL.
// Files that check their own logic include this header inside the module body.
`ifndef FIXED_POINT_DECIMAL_FORMATTER_ASSERT_SVH
`define FIXED_POINT_DECIMAL_FORMATTER_ASSERT_SVH

// Check that the antecedent implies the consequent in the next cycle.
`define FPDF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("formatter next-cycle check failed");

// Check that the antecedent implies the consequent in the same cycle.
`define FPDF_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("formatter same-cycle check failed");

`endif

[src/fpdf_pkg.sv]
// Shared types, constants and helpers of the decimal formatter.
// No dependencies; every other RTL file imports this package.
package fpdf_pkg;

  localparam int VALUE_W    = 28;
  localparam int PLACES_W   = 3;
  localparam int CHAR_W     = 7;
  localparam int DIGITS_DEF = 8;

  // Double-dabble conversion split over equal register stages.
  localparam int DD_STAGES = 4;
  localparam int DD_STEP   = VALUE_W / DD_STAGES;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] CH_POINT = 7'h2E;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ZERO,
    ST_SIGN,
    ST_DIG,
    ST_PNT
  } fpdf_state_t;

  typedef struct packed {
    logic                neg;
    logic                zero;
    logic [PLACES_W-1:0] places;
  } fpdf_tag_t;

  // Largest magnitude that fits in n decimal digits.
  function automatic longint unsigned fpdf_limit(input int n);
    longint unsigned acc;
    acc = 64'd1;
    for (int i = 0; i < n; i++) begin
      acc = acc * 64'd10;
    end
    return acc - 64'd1;
  endfunction

endpackage

[src/fpdf_prep.sv]
// Input stage: takes the magnitude of the value and clamps it to DIGITS digits.
// Depends on fpdf_pkg.
module fpdf_prep #(
  parameter int DIGITS = fpdf_pkg::DIGITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          in_v,
  input  logic [fpdf_pkg::VALUE_W-1:0]  value,
  input  logic [fpdf_pkg::PLACES_W-1:0] places,
  output logic                          out_v,
  output fpdf_pkg::fpdf_tag_t           out_tag,
  output logic [fpdf_pkg::VALUE_W-1:0]  out_bin
);
  import fpdf_pkg::*;

  localparam longint unsigned SAT_LIMIT = fpdf_limit(DIGITS);

  logic                v_r;
  fpdf_tag_t           tag_r;
  logic [VALUE_W-1:0]  bin_r;
  logic                neg;
  logic [VALUE_W-1:0]  mag;
  logic [VALUE_W-1:0]  bin_nxt;
  fpdf_tag_t           tag_nxt;

  always_comb begin
    neg = value[VALUE_W-1];
    mag = neg ? (~value + 1'b1) : value;
    if (64'(mag) > SAT_LIMIT) begin
      bin_nxt = SAT_LIMIT[VALUE_W-1:0];
    end else begin
      bin_nxt = mag;
    end
    tag_nxt.neg    = neg;
    tag_nxt.zero   = (value == '0);
    tag_nxt.places = places;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tag_r <= tag_nxt;
      bin_r <= bin_nxt;
    end
  end

  assign out_v   = v_r;
  assign out_tag = tag_r;
  assign out_bin = bin_r;

endmodule

[src/fpdf_dabble.sv]
// One double-dabble stage: shifts DD_STEP binary bits into the BCD register.
// Depends on fpdf_pkg.
module fpdf_dabble #(
  parameter int DIGITS = fpdf_pkg::DIGITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic                         in_v,
  input  fpdf_pkg::fpdf_tag_t          in_tag,
  input  logic [fpdf_pkg::VALUE_W-1:0] in_bin,
  input  logic [4*DIGITS-1:0]          in_bcd,
  output logic                         out_v,
  output fpdf_pkg::fpdf_tag_t          out_tag,
  output logic [fpdf_pkg::VALUE_W-1:0] out_bin,
  output logic [4*DIGITS-1:0]          out_bcd
);
  import fpdf_pkg::*;

  localparam int BCD_W = 4 * DIGITS;

  logic               v_r;
  fpdf_tag_t          tag_r;
  logic [VALUE_W-1:0] bin_r;
  logic [BCD_W-1:0]   bcd_r;
  logic [VALUE_W-1:0] bin_nxt;
  logic [BCD_W-1:0]   bcd_nxt;

  always_comb begin
    bcd_nxt = in_bcd;
    bin_nxt = in_bin;
    for (int s = 0; s < DD_STEP; s++) begin
      // adjust every nibble that would overflow on the doubling shift
      for (int n = 0; n < DIGITS; n++) begin
        if (bcd_nxt[4*n +: 4] >= 4'd5) begin
          bcd_nxt[4*n +: 4] = bcd_nxt[4*n +: 4] + 4'd3;
        end
      end
      bcd_nxt = {bcd_nxt[BCD_W-2:0], bin_nxt[VALUE_W-1]};
      bin_nxt = {bin_nxt[VALUE_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tag_r <= in_tag;
      bin_r <= bin_nxt;
      bcd_r <= bcd_nxt;
    end
  end

  assign out_v   = v_r;
  assign out_tag = tag_r;
  assign out_bin = bin_r;
  assign out_bcd = bcd_r;

endmodule

[src/fpdf_emit.sv]
// Character serializer: walks the BCD digits and emits sign, digits and point.
// Depends on fpdf_pkg and the assertion macro header.
module fpdf_emit #(
  parameter int DIGITS = fpdf_pkg::DIGITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_v,
  input  fpdf_pkg::fpdf_tag_t         in_tag,
  input  logic [4*DIGITS-1:0]         in_bcd,
  output logic                        ready,
  output logic                        out_valid,
  output logic [fpdf_pkg::CHAR_W-1:0] out_character,
  output logic                        out_last
);
  import fpdf_pkg::*;
  `include "fixed_point_decimal_formatter_assert.svh"

  localparam int BCD_W = 4 * DIGITS;
  localparam int KW    = $clog2(DIGITS);
  localparam logic [KW-1:0] K_LAST = KW'(DIGITS - 1);

  fpdf_state_t       st_r, st_nxt;
  logic [KW-1:0]     k_r, k_nxt;
  logic              started_r, started_nxt;
  logic              pt_en_r, pt_en_nxt;
  logic [KW-1:0]     pt_idx_r, pt_idx_nxt;
  logic [BCD_W-1:0]  bcd_r, bcd_nxt;
  logic              ov_r, ov_nxt;
  logic [CHAR_W-1:0] ch_r, ch_nxt;
  logic              last_r, last_nxt;
  logic [3:0]        dig;
  logic [CHAR_W-1:0] dig_ch;
  logic              take;

  assign dig    = bcd_r[BCD_W-1 -: 4];
  assign dig_ch = CH_ZERO + {3'b000, dig};
  assign take   = in_v && ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r       <= k_nxt;
    started_r <= started_nxt;
    pt_en_r   <= pt_en_nxt;
    pt_idx_r  <= pt_idx_nxt;
    bcd_r     <= bcd_nxt;
    ch_r      <= ch_nxt;
    last_r    <= last_nxt;
  end

  always_comb begin
    st_nxt      = st_r;
    k_nxt       = k_r;
    started_nxt = started_r;
    pt_en_nxt   = pt_en_r;
    pt_idx_nxt  = pt_idx_r;
    bcd_nxt     = bcd_r;
    ov_nxt      = 1'b0;
    ch_nxt      = CH_ZERO;
    last_nxt    = 1'b0;
    ready       = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        ready = 1'b1;
      end
      ST_ZERO: begin
        ov_nxt   = 1'b1;
        last_nxt = 1'b1;
        ready    = 1'b1;
        st_nxt   = ST_IDLE;
      end
      ST_SIGN: begin
        ov_nxt = 1'b1;
        ch_nxt = CH_MINUS;
        st_nxt = ST_DIG;
      end
      ST_DIG: begin
        if (k_r == K_LAST) begin
          ov_nxt   = 1'b1;
          ch_nxt   = dig_ch;
          last_nxt = 1'b1;
          ready    = 1'b1;
          st_nxt   = ST_IDLE;
        end else if (pt_en_r && (k_r == pt_idx_r)) begin
          // a zero digit here is the lone '0' before the point
          ov_nxt = 1'b1;
          ch_nxt = dig_ch;
          st_nxt = ST_PNT;
        end else begin
          if (dig != 4'd0 || started_r) begin
            ov_nxt      = 1'b1;
            ch_nxt      = dig_ch;
            started_nxt = 1'b1;
          end
          k_nxt   = k_r + 1'b1;
          bcd_nxt = {bcd_r[BCD_W-5:0], 4'd0};
        end
      end
      ST_PNT: begin
        ov_nxt      = 1'b1;
        ch_nxt      = CH_POINT;
        started_nxt = 1'b1;
        k_nxt       = k_r + 1'b1;
        bcd_nxt     = {bcd_r[BCD_W-5:0], 4'd0};
        st_nxt      = ST_DIG;
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase

    // load the next beat's digits when idle or once the current number is finishing
    if (take) begin
      if (in_tag.zero) begin
        st_nxt = ST_ZERO;
      end else if (in_tag.neg) begin
        st_nxt = ST_SIGN;
      end else begin
        st_nxt = ST_DIG;
      end
      k_nxt       = '0;
      started_nxt = 1'b0;
      pt_en_nxt   = (in_tag.places != '0) && (int'(in_tag.places) <= DIGITS - 1);
      pt_idx_nxt  = KW'(DIGITS - 1 - int'(in_tag.places));
      bcd_nxt     = in_bcd;
    end
  end

  assign out_valid     = ov_r;
  assign out_character = ch_r;
  assign out_last      = last_r;

  `FPDF_ASSERT_NEXT(a_zero_char, st_r == ST_ZERO,
                    ov_r && last_r && (ch_r == CH_ZERO))
  `FPDF_ASSERT_NEXT(a_sign_char, st_r == ST_SIGN,
                    ov_r && !last_r && (ch_r == CH_MINUS))
  `FPDF_ASSERT_NEXT(a_point_char, st_r == ST_PNT,
                    ov_r && !last_r && (ch_r == CH_POINT))
  `FPDF_ASSERT_SAME(a_more_follow, ov_r && !last_r,
                    (st_r == ST_DIG) || (st_r == ST_PNT))

endmodule

[src/fixed_point_decimal_formatter.sv]
// Fixed-point decimal formatter, top level: input clamp, double-dabble pipeline,
// character serializer. Depends on fpdf_pkg, fpdf_prep, fpdf_dabble, fpdf_emit.
//
// Usage:
//   Drive in_value (28-bit two's complement) and in_decimal_places with start
//   high; the beat is taken at a rising edge where busy is low. The number comes
//   back as ASCII text, one character per out_valid strobe, with out_last on the
//   final character: optional '-', digits without leading zeros, a '.' before
//   the last in_decimal_places digits (a '0' leads when no digit came first).
//   Zero prints "0"; magnitudes beyond DIGITS digits clamp to all nines.
// Pipeline and flow:
//   One clamp stage and DD_STAGES (4) dabble stages, then the serializer loads
//   the digits. For a nonzero value the serializer steps through every digit
//   position, plus one step for a sign and one for a point when printed; it
//   takes the next number only while idle or while finishing the current one.
//   Up to five numbers queue in the conversion pipeline; busy rises, and the
//   whole pipeline holds, while its last stage holds a number that the
//   serializer cannot take yet.
// Reset clears all valid bits and the serializer state; data registers are not reset.
// The receiver cannot stall: every out_valid strobe is a delivered character.
module fixed_point_decimal_formatter #(
  parameter int DIGITS = fpdf_pkg::DIGITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [fpdf_pkg::VALUE_W-1:0]  in_value,
  input  logic [fpdf_pkg::PLACES_W-1:0] in_decimal_places,
  output logic                          out_valid,
  output logic [fpdf_pkg::CHAR_W-1:0]   out_character,
  output logic                          out_last
);
  import fpdf_pkg::*;

  localparam int BCD_W = 4 * DIGITS;

  logic                     adv;
  logic                     ser_ready;
  logic [DD_STAGES:0]       v_s;
  fpdf_tag_t                tag_s [DD_STAGES+1];
  logic [VALUE_W-1:0]       bin_s [DD_STAGES+1];
  logic [BCD_W-1:0]         bcd_s [DD_STAGES+1];

  // whole pipeline holds while its last stage waits on the serializer
  assign adv   = !v_s[DD_STAGES] || ser_ready;
  assign busy  = !adv;

  assign bcd_s[0] = '0;

  fpdf_prep #(
    .DIGITS (DIGITS)
  ) u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_v    (start && adv),
    .value   (in_value),
    .places  (in_decimal_places),
    .out_v   (v_s[0]),
    .out_tag (tag_s[0]),
    .out_bin (bin_s[0])
  );

  for (genvar g = 0; g < DD_STAGES; g++) begin : g_dd
    fpdf_dabble #(
      .DIGITS (DIGITS)
    ) u_dabble (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .in_v    (v_s[g]),
      .in_tag  (tag_s[g]),
      .in_bin  (bin_s[g]),
      .in_bcd  (bcd_s[g]),
      .out_v   (v_s[g+1]),
      .out_tag (tag_s[g+1]),
      .out_bin (bin_s[g+1]),
      .out_bcd (bcd_s[g+1])
    );
  end

  fpdf_emit #(
    .DIGITS (DIGITS)
  ) u_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_v          (v_s[DD_STAGES]),
    .in_tag        (tag_s[DD_STAGES]),
    .in_bcd        (bcd_s[DD_STAGES]),
    .ready         (ser_ready),
    .out_valid     (out_valid),
    .out_character (out_character),
    .out_last      (out_last)
  );

endmodule
